### design/bc13_pkg.sv
`timescale 1ns / 1ps
// Shared types, register map and arithmetic helpers for the BC1/BC3 block decoder.
// No dependencies; used by bc13_tbl, bc13_rows and bc1_bc3_block_decoder_unit.
package bc13_pkg;

  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned InDataW   = 128;
  localparam int unsigned OutDataW  = 136;
  localparam int unsigned TexelW    = 32;

  // Register word indexes (byte address divided by four).
  localparam logic [ApbAddrW-3:0] RegIdxFormatMode = 1'b0;

  typedef enum logic {
    FMT_BC1 = 1'b0,
    FMT_BC3 = 1'b1
  } fmt_mode_e;

  // Decoded lookup tables for one block.
  typedef struct packed {
    logic [3:0][TexelW-1:0] pal;
    logic [7:0][7:0]        atab;
  } blk_tables_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(x / 3) for x <= 767, by reciprocal multiply.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // floor(x / 5) for x <= 1277.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = {13'd0, x} * 24'd6554;
    return p[22:15];
  endfunction

  // floor(x / 7) for x <= 1788.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = {13'd0, x} * 24'd4682;
    return p[22:15];
  endfunction

endpackage

### design/bc1_bc3_block_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the BC1/BC3 block decoder: APB register, input register and stream ports.
// Depends on bc13_pkg, bc13_tbl and bc13_rows.
//
//   Channel   Direction  Payload
//   s_axis    in         one compressed block per transaction (colour and alpha halves)
//   m_axis    out        one texel row per transaction, tlast on the fourth row
//   apb       in/out     format_mode register at byte address 0
//
// A block is accepted into the input register, its palette and alpha table are built
// between that register and the row sequencer, and its four rows leave one per cycle
// while m_axis does not stall; the next block is accepted while the last row is sent.
// A block passes the input, row sequencer and output registers on its way to m_axis.
// Reset clears the register and all valid flags. A stall on m_axis holds the output
// register and backs up through the row sequencer to s_axis tready.
module bc1_bc3_block_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bc13_pkg::ApbAddrW-1:0]    paddr,
  input  logic [bc13_pkg::ApbDataW-1:0]    pwdata,
  output logic [bc13_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: color_block[63:0], alpha_block[127:64].
  input  logic [bc13_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: row_index[1:0], texel0[33:2], texel1[65:34], texel2[97:66],
  // texel3[129:98], zero fill [135:130].
  output logic [bc13_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import bc13_pkg::*;

  fmt_mode_e        mode_q, mode_d;
  logic             in_valid_q, in_valid_d;
  logic [63:0]      color_q, alpha_q;
  logic             rows_ready;
  blk_tables_t      tables;
  logic [1:0]       out_row;
  logic [3:0][31:0] out_tex;
  logic             reg_wr, reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ApbAddrW-1:2] == RegIdxFormatMode);
  assign reg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {{(ApbDataW-1){1'b0}}, mode_q} : '0;

  always_comb begin
    mode_d = mode_q;
    if (reg_wr) begin
      mode_d = fmt_mode_e'(pwdata[0]);
    end
  end

  assign s_axis_tready = !in_valid_q || rows_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (rows_ready) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= FMT_BC1;
      in_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      color_q <= s_axis_tdata[63:0];
      alpha_q <= s_axis_tdata[127:64];
    end
  end

  bc13_tbl u_tbl (
    .color_blk_i (color_q),
    .alpha_blk_i (alpha_q),
    .tables_o    (tables)
  );

  bc13_rows u_rows (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_valid_i  (in_valid_q),
    .blk_ready_o  (rows_ready),
    .tables_i     (tables),
    .cidx_i       (color_q[63:32]),
    .aidx_i       (alpha_q[63:16]),
    .mode_i       (mode_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row),
    .out_texels_o (out_tex),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_tex[3], out_tex[2], out_tex[1], out_tex[0], out_row};

endmodule

### design/bc13_tbl.sv
`timescale 1ns / 1ps
// Colour palette and alpha table construction for one compressed block.
// Purely combinational; depends on bc13_pkg.
module bc13_tbl (
  input  logic [63:0]              color_blk_i,
  input  logic [63:0]              alpha_blk_i,
  output bc13_pkg::blk_tables_t    tables_o
);
  import bc13_pkg::*;

  logic [15:0]     c0, c1;
  logic [2:0][7:0] e0, e1;
  logic [7:0]      a0, a1;

  assign c0 = color_blk_i[15:0];
  assign c1 = color_blk_i[31:16];
  assign a0 = alpha_blk_i[7:0];
  assign a1 = alpha_blk_i[15:8];

  // Channel order: R, G, B.
  assign e0[0] = widen5(c0[15:11]);
  assign e0[1] = widen6(c0[10:5]);
  assign e0[2] = widen5(c0[4:0]);
  assign e1[0] = widen5(c1[15:11]);
  assign e1[1] = widen6(c1[10:5]);
  assign e1[2] = widen5(c1[4:0]);

  always_comb begin
    logic [2:0][7:0] third0, third1, mid;
    logic [8:0]      msum;
    logic [10:0]     s7, s5;
    s7 = '0;
    s5 = '0;
    for (int ch = 0; ch < 3; ch++) begin
      third0[ch] = div3({1'b0, e0[ch], 1'b0} + {2'b0, e1[ch]} + 10'd1);
      third1[ch] = div3({2'b0, e0[ch]} + {1'b0, e1[ch], 1'b0} + 10'd1);
      msum       = {1'b0, e0[ch]} + {1'b0, e1[ch]};
      mid[ch]    = msum[8:1];
    end

    tables_o.pal[0] = {8'hFF, e0[2], e0[1], e0[0]};
    tables_o.pal[1] = {8'hFF, e1[2], e1[1], e1[0]};
    if (c0 > c1) begin
      tables_o.pal[2] = {8'hFF, third0[2], third0[1], third0[0]};
      tables_o.pal[3] = {8'hFF, third1[2], third1[1], third1[0]};
    end else begin
      tables_o.pal[2] = {8'hFF, mid[2], mid[1], mid[0]};
      tables_o.pal[3] = '0;
    end

    tables_o.atab[0] = a0;
    tables_o.atab[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        s7 = 11'(7 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1} + 11'd3;
        tables_o.atab[i + 1] = div7(s7);
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        s5 = 11'(5 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1} + 11'd2;
        tables_o.atab[i + 1] = div5(s5);
      end
      tables_o.atab[6] = 8'd0;
      tables_o.atab[7] = 8'd255;
    end
  end

endmodule

### design/bc13_rows.sv
`timescale 1ns / 1ps
// Row sequencer: holds one block's tables and indices and emits one texel row per cycle
// into a registered output stage while that stage is free. Depends on bc13_pkg.
module bc13_rows (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   blk_valid_i,
  output logic                   blk_ready_o,
  input  bc13_pkg::blk_tables_t  tables_i,
  input  logic [31:0]            cidx_i,
  input  logic [47:0]            aidx_i,
  input  bc13_pkg::fmt_mode_e    mode_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             out_row_o,
  output logic [3:0][31:0]       out_texels_o,
  output logic                   out_last_o
);
  import bc13_pkg::*;

  logic                     busy_q, busy_d;
  logic [1:0]               row_q, row_d;
  blk_tables_t              tbl_q;
  logic [3:0][7:0]          cidx_q;
  logic [3:0][11:0]         aidx_q;
  fmt_mode_e                mode_q;
  logic                     ovalid_q, ovalid_d;
  logic [1:0]               orow_q;
  logic [3:0][TexelW-1:0]   otex_q, tex_row;
  logic                     olast_q;
  logic                     out_free, emit, load;

  assign out_free    = !ovalid_q || out_ready_i;
  assign emit        = busy_q && out_free;
  assign blk_ready_o = !busy_q || (emit && row_q == 2'd3);
  assign load        = blk_valid_i && blk_ready_o;

  always_comb begin
    logic [7:0]        crow;
    logic [11:0]       arow;
    logic [1:0]        ci;
    logic [2:0]        ai;
    logic [TexelW-1:0] base;
    crow = cidx_q[row_q];
    arow = aidx_q[row_q];
    for (int c = 0; c < 4; c++) begin
      ci   = crow[2*c +: 2];
      ai   = arow[3*c +: 3];
      base = tbl_q.pal[ci];
      if (mode_q == FMT_BC3) begin
        tex_row[c] = {tbl_q.atab[ai], base[23:0]};
      end else begin
        tex_row[c] = base;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (emit) begin
      row_d = row_q + 2'd1;
      if (row_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      row_d  = 2'd0;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      row_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      row_q    <= row_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tbl_q  <= tables_i;
      cidx_q <= cidx_i;
      aidx_q <= aidx_i;
      mode_q <= mode_i;
    end
    if (emit) begin
      orow_q  <= row_q;
      otex_q  <= tex_row;
      olast_q <= (row_q == 2'd3);
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_row_o    = orow_q;
  assign out_texels_o = otex_q;
  assign out_last_o   = olast_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bc1_bc3_block_decoder_unit: random and directed BC1/BC3 blocks
// against a texel predictor. Depends on bc13_pkg and the decoder RTL only.
module tb;
  import bc13_pkg::*;

  localparam logic [ApbAddrW-1:0] FmtModeAddr = {RegIdxFormatMode, 2'b00};
  localparam logic [ApbAddrW-1:0] SpareAddr   = 3'd4;
  // Three-bit alpha indices 0..7 twice over, so every table entry is selected.
  localparam logic [47:0]         AlphaRamp   = 48'hFAC688FAC688;
  localparam int unsigned         QuietLimit  = 3000;

  typedef struct packed {
    logic [1:0]        row_idx;
    logic [3:0][31:0]  texels;
    logic              last;
  } texel_row_t;

  class texel_row_board;
    texel_row_t  rows_q[$];
    fmt_mode_e   mode = FMT_BC1;
    int unsigned mismatches = 0;

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Decodes one accepted block into its four expected rows.
    function void note_block(logic [63:0] cblk, logic [63:0] ablk);
      logic [15:0]  c0, c1;
      logic [7:0]   a0, a1;
      int unsigned  e0[3], e1[3];
      logic [31:0]  pal[4];
      logic [7:0]   atab[8];
      logic [31:0]  texel;
      texel_row_t   r;
      int unsigned  t;
      c0 = cblk[15:0];
      c1 = cblk[31:16];
      a0 = ablk[7:0];
      a1 = ablk[15:8];
      e0[0] = {c0[15:11], c0[15:13]};
      e0[1] = {c0[10:5], c0[10:9]};
      e0[2] = {c0[4:0], c0[4:2]};
      e1[0] = {c1[15:11], c1[15:13]};
      e1[1] = {c1[10:5], c1[10:9]};
      e1[2] = {c1[4:0], c1[4:2]};
      pal[0] = {8'hFF, 8'(e0[2]), 8'(e0[1]), 8'(e0[0])};
      pal[1] = {8'hFF, 8'(e1[2]), 8'(e1[1]), 8'(e1[0])};
      for (int k = 0; k < 3; k++) begin
        if (c0 > c1) begin
          pal[2][8*k +: 8] = 8'((2 * e0[k] + e1[k] + 1) / 3);
          pal[3][8*k +: 8] = 8'((e0[k] + 2 * e1[k] + 1) / 3);
        end else begin
          pal[2][8*k +: 8] = 8'((e0[k] + e1[k]) >> 1);
          pal[3][8*k +: 8] = 8'h00;
        end
      end
      pal[2][31:24] = 8'hFF;
      pal[3][31:24] = (c0 > c1) ? 8'hFF : 8'h00;

      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
        for (int i = 1; i <= 6; i++)
          atab[i+1] = 8'(((7 - i) * a0 + i * a1 + 3) / 7);
      end else begin
        for (int i = 1; i <= 4; i++)
          atab[i+1] = 8'(((5 - i) * a0 + i * a1 + 2) / 5);
        atab[6] = 8'd0;
        atab[7] = 8'd255;
      end

      for (int row = 0; row < 4; row++) begin
        r.row_idx = 2'(row);
        r.last    = (row == 3);
        for (int col = 0; col < 4; col++) begin
          t = row * 4 + col;
          texel = pal[cblk[32 + 2*t +: 2]];
          if (mode == FMT_BC3) texel[31:24] = atab[ablk[16 + 3*t +: 3]];
          r.texels[col] = texel;
        end
        rows_q.push_back(r);
      end
    endfunction

    task check_row(texel_row_t got);
      texel_row_t want;
      if (rows_q.size() == 0) begin
        report_mismatch($sformatf("row %0d arrived with no block pending", got.row_idx));
        return;
      end
      want = rows_q.pop_front();
      if (got.row_idx !== want.row_idx)
        report_mismatch($sformatf("row_index %0d, expected %0d", got.row_idx, want.row_idx));
      for (int k = 0; k < 4; k++) begin
        if (got.texels[k] !== want.texels[k])
          report_mismatch($sformatf("row %0d texel%0d %08h, expected %08h",
                                    want.row_idx, k, got.texels[k], want.texels[k]));
      end
      if (got.last !== want.last)
        report_mismatch($sformatf("row %0d tlast %b, expected %b",
                                  want.row_idx, got.last, want.last));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel, penable, pwrite;
  logic [ApbAddrW-1:0]   paddr;
  logic [ApbDataW-1:0]   pwdata;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // Fields from bit 0: color_block[63:0], alpha_block[127:64].
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // Fields from bit 0: row_index[1:0], texel0..texel3 (32 bits each), zero fill.
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;

  texel_row_board        rows_sb;
  bit                    tx_steady = 1'b0;
  bit                    rx_steady = 1'b0;
  int unsigned           rx_hold = 0;
  int unsigned           quiet_cycles = 0;

  bc1_bc3_block_decoder_unit uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sampling happens before any register of the edge updates, so both sides see
  // the values that decided the handshake.
  always @(posedge clk_i) begin : stream_monitor
    texel_row_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        rows_sb.note_block(s_axis_tdata[63:0], s_axis_tdata[127:64]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.row_idx = m_axis_tdata[1:0];
        for (int k = 0; k < 4; k++) got.texels[k] = m_axis_tdata[2 + 32*k +: 32];
        got.last = m_axis_tlast;
        rows_sb.check_row(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("bc1_bc3_block_decoder_unit verification failed");
      $finish;
    end
  end

  // Row receiver: a random stall before each row unless rx_steady is set, or a long hold-off when requested.
  initial begin : row_receiver
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold != 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task send_block(input logic [63:0] cblk, input logic [63:0] ablk);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ablk, cblk};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering blocks and waits until every expected row has left the decoder.
  // The first edge lets the monitor record a transaction accepted at the current edge.
  task settle_decoder();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rows_sb.rows_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == FmtModeAddr) rows_sb.mode = fmt_mode_e'(data[0]);
  endtask

  task check_mode_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FmtModeAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== rows_sb.mode)
      rows_sb.report_mismatch($sformatf("format_mode reads %b, expected %b",
                                        prdata[0], rows_sb.mode));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task pick_block(output logic [63:0] cblk, output logic [63:0] ablk);
    cblk = {$urandom, $urandom};
    ablk = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: cblk[31:16] = cblk[15:0];
      1: ablk[15:8]  = ablk[7:0];
      2: begin
        cblk[15:0] = {16{cblk[15]}};
        ablk[7:0]  = {8{ablk[7]}};
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [63:0] cblk, ablk;
    rows_sb = new();
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // BC1 straight out of reset: both palette branches, equal endpoints, and an
    // alpha half that has to be ignored.
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'h0);
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0);
    send_block({32'hE4E4E4E4, 16'h1234, 16'h1234}, {AlphaRamp, 8'h00, 8'hFF});
    send_block(64'h0, 64'h0);
    send_block({64{1'b1}}, {64{1'b1}});
    send_block({32'h1B1B1B1B, 16'h7FFF, 16'h8000}, 64'h0);
    send_block({32'hAAAA5555, 16'h001F, 16'hF800}, {AlphaRamp, 8'h55, 8'hAA});
    send_block({32'hE4E4E4E4, 16'hF800, 16'h07E0}, 64'h0);
    settle_decoder();
    apb_write(SpareAddr, 32'h1);
    check_mode_readback();
    apb_write(FmtModeAddr, 32'hFFFF_FFF1);
    check_mode_readback();

    // BC3: both alpha table branches, equal alpha endpoints, transparent colour entry.
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {AlphaRamp, 8'h00, 8'hFF});
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {AlphaRamp, 8'hFF, 8'h00});
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {AlphaRamp, 8'h80, 8'h80});
    send_block({32'h1B1B1B1B, 16'h0000, 16'hFFFF}, {AlphaRamp, 8'h00, 8'h01});
    send_block(64'h0, 64'h0);
    send_block({64{1'b1}}, {64{1'b1}});
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {AlphaRamp, 8'h10, 8'hF3});
    send_block({32'h4E4E4E4E, 16'h07E0, 16'h001F}, {AlphaRamp, 8'hC8, 8'h07});
    settle_decoder();
    apb_write(SpareAddr, 32'h0);
    check_mode_readback();

    for (int phase = 0; phase < 6; phase++) begin
      apb_write(FmtModeAddr, ($urandom & 32'hFFFF_FFFE) | 32'(phase % 2));
      check_mode_readback();
      tx_steady = (phase == 1) || (phase == 3);
      rx_steady = (phase == 2);
      // The sender keeps offering during the hold-off, so the decoder fills and stalls.
      if (phase == 3) rx_hold = 160;
      for (int n = 0; n < 42; n++) begin
        pick_block(cblk, ablk);
        send_block(cblk, ablk);
        if (phase == 4 && n == 20) settle_decoder();
      end
      settle_decoder();
    end

    repeat (6) @(posedge clk_i);
    if (rows_sb.mismatches == 0 && rows_sb.rows_q.size() == 0) begin
      $display("bc1_bc3_block_decoder_unit verification clean");
    end else begin
      $display("bc1_bc3_block_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
